[hdl/pcrd_pkg.sv]
// ----------------------------------------------------------------------------
// Power change report detector package
// Shared widths, register indexes, reset values and the command and status
// types that join the controller and the datapath.
// ----------------------------------------------------------------------------
package pcrd_pkg;

   // Depth of the power history; entry 0 is the oldest.
   localparam int HISTORY_DEPTH = 3;

   // Field widths.
   localparam int POWER_W     = 16;
   localparam int SECONDS_W   = 32;
   localparam int SETTLE_W    = 8;
   localparam int CFG_W       = 12;
   localparam int CSR_INDEX_W = 2;

   // Percent test: diff * 100 against (threshold + 1) * min, both fit 23 bits.
   localparam int MULB_W = 7;
   localparam int PROD_W = POWER_W + MULB_W;

   // Remainder unit: one dividend bit per cycle.
   localparam int DIV_STEPS   = SECONDS_W;
   localparam int DIV_COUNT_W = $clog2(DIV_STEPS);

   typedef logic [POWER_W-1:0]     power_type;
   typedef logic [CFG_W-1:0]       cfg_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // Register indexes.
   localparam csr_index_type CSR_DELTA_THRESHOLD = csr_index_type'(0);
   localparam csr_index_type CSR_REPORT_PERIOD   = csr_index_type'(1);

   // Reset values and constants.
   localparam cfg_type            DELTA_RESET  = cfg_type'(10);
   localparam cfg_type            PERIOD_RESET = cfg_type'(60);
   localparam cfg_type            PCT_LIMIT    = cfg_type'(100);
   localparam logic [MULB_W-1:0]  PCT_SCALE    = MULB_W'(100);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // take the input beat, load settle counter on settle_load
      logic mod_start;   // start the seconds remainder
      logic skip;        // settle counter running: count down, flags zero
      logic diff_load;   // register difference and minimum
      logic mul_diff;    // register diff * 100
      logic mul_thr;     // register (threshold + 1) * minimum
      logic commit;      // decide, update history, set flags
   } pcrd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic settle_busy;
      logic mod_done;
   } pcrd_status_type;

endpackage

[hdl/pcrd_ifs.sv]
// ----------------------------------------------------------------------------
// Power change report detector channels
// Valid/ready channels for the sample input, the result output and the
// register write port.
// ----------------------------------------------------------------------------
interface pcrd_req_if;
   logic                              valid;
   logic                              ready;
   logic [pcrd_pkg::POWER_W-1:0]      power_watts;
   logic [pcrd_pkg::SECONDS_W-1:0]    seconds_now;
   logic                              settle_load;
   logic [pcrd_pkg::SETTLE_W-1:0]     settle_count;

   modport source (output valid, power_watts, seconds_now, settle_load, settle_count,
                   input ready);
   modport sink   (input valid, power_watts, seconds_now, settle_load, settle_count,
                   output ready);
endinterface

interface pcrd_rsp_if;
   logic valid;
   logic ready;
   logic report_power;
   logic report_energy;

   modport source (output valid, report_power, report_energy, input ready);
   modport sink   (input valid, report_power, report_energy, output ready);
endinterface

interface pcrd_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [pcrd_pkg::CSR_INDEX_W-1:0]     index;
   logic [pcrd_pkg::CFG_W-1:0]           data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hdl/pcrd_mod_unit.sv]
// ----------------------------------------------------------------------------
// Seconds remainder unit
// Restoring remainder of the seconds count by the report period, one
// dividend bit per cycle; reports whether the remainder is zero.
// ----------------------------------------------------------------------------
module pcrd_mod_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pcrd_pkg::SECONDS_W-1:0]   dividend,
   input  logic [pcrd_pkg::CFG_W-1:0]       divisor,
   output logic                             done,
   output logic                             rem_zero
);

   logic [pcrd_pkg::SECONDS_W-1:0]   quot_ff, quot_in;
   logic [pcrd_pkg::CFG_W-1:0]       rem_ff, rem_in;
   logic [pcrd_pkg::CFG_W-1:0]       divisor_ff, divisor_in;
   logic [pcrd_pkg::DIV_COUNT_W-1:0] count_ff, count_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [pcrd_pkg::CFG_W:0]         trial;

   // One restoring step: bring in the next dividend bit, subtract if it fits.
   always_comb begin
      trial      = {rem_ff, quot_ff[pcrd_pkg::SECONDS_W-1]};
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = done_ff;
      if (start) begin
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         count_in   = '0;
         busy_in    = 1'b1;
         done_in    = 1'b0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[pcrd_pkg::SECONDS_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = pcrd_pkg::CFG_W'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[pcrd_pkg::CFG_W-1:0];
         end
         count_in = count_ff + 1'b1;
         if (count_ff == pcrd_pkg::DIV_COUNT_W'(pcrd_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the operand registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

[hdl/pcrd_datapath.sv]
// ----------------------------------------------------------------------------
// Power change report detector datapath
// Configuration registers, power history, settle counter, the shared
// multiplier of the percent test and the result flags.
// ----------------------------------------------------------------------------
module pcrd_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [pcrd_pkg::POWER_W-1:0]     power_watts,
   input  logic [pcrd_pkg::SECONDS_W-1:0]   seconds_now,
   input  logic                             settle_load,
   input  logic [pcrd_pkg::SETTLE_W-1:0]    settle_count,
   input  logic                             csr_write,
   input  logic [pcrd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pcrd_pkg::CFG_W-1:0]       csr_data,
   input  pcrd_pkg::pcrd_cmd_type           cmd,
   output pcrd_pkg::pcrd_status_type        status,
   output logic                             report_power,
   output logic                             report_energy
);

   pcrd_pkg::cfg_type                delta_ff, period_ff;
   pcrd_pkg::power_type              hist_ff [pcrd_pkg::HISTORY_DEPTH];
   logic [pcrd_pkg::SETTLE_W-1:0]    settle_ff;
   pcrd_pkg::power_type              power_ff;
   pcrd_pkg::power_type              diff_ff, diff_in;
   pcrd_pkg::power_type              lo_ff, lo_in;
   logic [pcrd_pkg::PROD_W-1:0]      prod_diff_ff, prod_thr_ff, product;
   logic [pcrd_pkg::PROD_W-1:0]      mul_a, mul_b;
   logic [pcrd_pkg::MULB_W-1:0]      thr_plus1;
   logic                             report_power_ff, report_energy_ff;
   logic                             mod_done, mod_zero;
   logic                             trip, periodic, pct_trip, abs_trip;

   // Remainder of the seconds count by the report period.
   pcrd_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.mod_start),
      .dividend (seconds_now),
      .divisor  (period_ff),
      .done     (mod_done),
      .rem_zero (mod_zero)
   );

   // Absolute difference and the minimum (zero counts as one).
   always_comb begin
      if (power_ff > hist_ff[0]) begin
         diff_in = power_ff - hist_ff[0];
         lo_in   = hist_ff[0];
      end else begin
         diff_in = hist_ff[0] - power_ff;
         lo_in   = power_ff;
      end
      if (lo_in == '0) begin
         lo_in = pcrd_pkg::POWER_W'(1);
      end
   end

   // One multiplier, used for diff * 100 and then (threshold + 1) * minimum.
   assign thr_plus1 = pcrd_pkg::MULB_W'(delta_ff + pcrd_pkg::CFG_W'(1));
   assign mul_a     = pcrd_pkg::PROD_W'(cmd.mul_thr ? lo_ff : diff_ff);
   assign mul_b     = pcrd_pkg::PROD_W'(cmd.mul_thr ? thr_plus1 : pcrd_pkg::PCT_SCALE);
   assign product   = mul_a * mul_b;

   // floor(diff * 100 / lo) > thr is the same as diff * 100 >= (thr + 1) * lo.
   assign pct_trip = (prod_diff_ff >= prod_thr_ff);
   assign abs_trip = (diff_ff > pcrd_pkg::POWER_W'(delta_ff - pcrd_pkg::PCT_LIMIT));
   assign trip     = (delta_ff != '0) && (diff_ff != '0) &&
                     ((delta_ff <= pcrd_pkg::PCT_LIMIT) ? pct_trip : abs_trip);
   assign periodic = (period_ff != '0) && mod_zero;

   // Configuration, history, settle counter and result flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff         <= pcrd_pkg::DELTA_RESET;
         period_ff        <= pcrd_pkg::PERIOD_RESET;
         settle_ff        <= '0;
         report_power_ff  <= 1'b0;
         report_energy_ff <= 1'b0;
         for (int i = 0; i < pcrd_pkg::HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         if (csr_write && (csr_index == pcrd_pkg::CSR_DELTA_THRESHOLD)) begin
            delta_ff <= csr_data;
         end
         if (csr_write && (csr_index == pcrd_pkg::CSR_REPORT_PERIOD)) begin
            period_ff <= csr_data;
         end
         if (cmd.capture && settle_load) begin
            settle_ff <= settle_count;
         end
         if (cmd.skip) begin
            settle_ff        <= settle_ff - 1'b1;
            report_power_ff  <= 1'b0;
            report_energy_ff <= 1'b0;
         end
         if (cmd.commit) begin
            // A trip fills the whole history with the current power.
            for (int i = 0; i < pcrd_pkg::HISTORY_DEPTH - 1; i++) begin
               hist_ff[i] <= trip ? power_ff : hist_ff[i+1];
            end
            hist_ff[pcrd_pkg::HISTORY_DEPTH-1] <= power_ff;
            report_power_ff  <= periodic;
            report_energy_ff <= periodic || trip;
         end
      end
   end

   // Working registers of the change test.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         power_ff <= power_watts;
      end
      if (cmd.diff_load) begin
         diff_ff <= diff_in;
         lo_ff   <= lo_in;
      end
      if (cmd.mul_diff) begin
         prod_diff_ff <= product;
      end
      if (cmd.mul_thr) begin
         prod_thr_ff <= product;
      end
   end

   assign status.settle_busy = (settle_ff != '0);
   assign status.mod_done    = mod_done;
   assign report_power       = report_power_ff;
   assign report_energy      = report_energy_ff;

endmodule

[hdl/pcrd_ctrl.sv]
// ----------------------------------------------------------------------------
// Power change report detector controller
// Sequences one sample through settle check, change test and remainder wait
// (skipped if settling), then holds the result until the output beat is taken.
// ----------------------------------------------------------------------------
module pcrd_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  pcrd_pkg::pcrd_status_type   status,
   output pcrd_pkg::pcrd_cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_DIFF,
      ST_MUL_THR,
      ST_WAIT,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state, registered handshake outputs and datapath commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.mod_start = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.settle_busy) begin
               cmd.skip = 1'b1;
               state_in = ST_OUT;
            end else begin
               cmd.diff_load = 1'b1;
               state_in      = ST_MUL_DIFF;
            end
         end
         ST_MUL_DIFF: begin
            cmd.mul_diff = 1'b1;
            state_in     = ST_MUL_THR;
         end
         ST_MUL_THR: begin
            cmd.mul_thr = 1'b1;
            state_in    = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.mod_done) begin
               cmd.commit = 1'b1;
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      req_ready_in = (state_in == ST_IDLE);
      rsp_valid_in = (state_in == ST_OUT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/power_change_report_detector_core.sv]
// ----------------------------------------------------------------------------
// Power change report detector core
// Decides per one-second sample whether a power or energy report is due.
// ----------------------------------------------------------------------------
// One sample is handled at a time. A sample that runs the change test has
// its result valid once the remainder unit is done, and the next input
// beat can be taken in the cycle after the result beat at the earliest,
// so a steady stream is paced by the remainder unit, which works through
// the 32-bit seconds count one bit per cycle. A sample that falls in a
// settle period skips the change test and has its result valid after the
// check state, without waiting for the remainder unit. Register writes are
// taken in any cycle but must only be issued while no sample is in flight.
module power_change_report_detector_core (
   input  logic              clock,
   input  logic              reset,
   pcrd_req_if.sink          req_bus,
   pcrd_rsp_if.source        rsp_bus,
   pcrd_csr_if.sink          csr_bus
);

   pcrd_pkg::pcrd_cmd_type    cmd;
   pcrd_pkg::pcrd_status_type status;

   // The register port never stalls.
   assign csr_bus.ready = 1'b1;

   pcrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcrd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .power_watts   (req_bus.power_watts),
      .seconds_now   (req_bus.seconds_now),
      .settle_load   (req_bus.settle_load),
      .settle_count  (req_bus.settle_count),
      .csr_write     (csr_bus.valid),
      .csr_index     (csr_bus.index),
      .csr_data      (csr_bus.data),
      .cmd           (cmd),
      .status        (status),
      .report_power  (rsp_bus.report_power),
      .report_energy (rsp_bus.report_energy)
   );

endmodule

[hdl/pcrd_checker.sv]
// ----------------------------------------------------------------------------
// Power change report detector checker
// Port-level checks of sequencing and result consistency.
// ----------------------------------------------------------------------------
module pcrd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic report_power,
   input logic report_energy
);

   // A result never appears in the cycle right after an input beat.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("result valid directly after input beat");

   // No new sample is taken while a result is pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while result pending");

   // A periodic report always implies an energy report.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && report_power) |-> report_energy)
      else $error("report_power without report_energy");

   // A stalled result stays valid.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind power_change_report_detector_core pcrd_checker u_pcrd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .report_power  (rsp_bus.report_power),
   .report_energy (rsp_bus.report_energy)
);
